>>> rtl/lcae_pkg.sv
// ----------------------------------------------------------------------------
// lcae_pkg
// Shared types and constants of the linear classifier argmax evaluator.
// ----------------------------------------------------------------------------
package lcae_pkg;

    // request commands
    typedef enum logic [1:0] {
        CMD_WRITE   = 2'd0,
        CMD_FEATURE = 2'd1,
        CMD_CLEAR   = 2'd2
    } t_cmd;

    // fixed field widths
    localparam int CMD_W     = 2;
    localparam int FIDX_W    = 3;
    localparam int CIDX_W    = 2;
    localparam int VALUE_W   = 16;
    localparam int CFG_W     = 3;
    localparam int PROD_W    = 32;
    localparam int SCORE_W   = 40;
    localparam int COUNT_W   = 32;

    // reset value of the class count register
    localparam logic [CFG_W-1:0] CLASSES_RESET = 3'd3;

    // depth of the queue between front and back
    localparam int Q_DEPTH   = 8;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_LEVEL_W = $clog2(Q_DEPTH + 1);

    // verdict handed from front to back
    typedef struct packed {
        logic              clear;
        logic [CIDX_W-1:0] pred;
        logic              miss;
    } t_verdict;

endpackage

>>> rtl/lcae_ram.sv
// ----------------------------------------------------------------------------
// lcae_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module lcae_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/lcae_front.sv
// ----------------------------------------------------------------------------
// lcae_front
// Accepts requests, stores weights, multiplies features into the class
// scores and picks the best class at the end of each sample.
// ----------------------------------------------------------------------------
module lcae_front
    import lcae_pkg::*;
#(
    parameter int MAX_FEATURES = 8,
    parameter int MAX_CLASSES  = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [CMD_W-1:0]          i_command,
    input  logic [FIDX_W-1:0]         i_feature_index,
    input  logic [CIDX_W-1:0]         i_class_index,
    input  logic signed [VALUE_W-1:0] i_weight_value,
    input  logic signed [VALUE_W-1:0] i_feature_value,
    input  logic                      i_last_feature,
    input  logic [CIDX_W-1:0]         i_true_class,
    input  logic                      i_cfg_we,
    input  logic [CFG_W-1:0]          i_cfg_wdata,
    input  logic [Q_LEVEL_W-1:0]      i_q_level,
    output logic                      o_q_push,
    output t_verdict                  o_q_data
);

    localparam int AW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int CW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int P  = 1 << CW;

    localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

    logic                        w_accept;
    logic                        w_is_write;
    logic                        w_is_feature;
    logic                        w_is_clear;
    logic [AW-1:0]               w_addr;
    logic                        w_fidx_ok;
    logic                        w_cidx_ok;
    logic signed [VALUE_W-1:0]   w_rd [MAX_CLASSES];

    logic [CFG_W-1:0]            r_classes;

    // stage 1: after the weight read
    logic                        r_s1_valid;
    logic                        r_s1_end;
    logic                        r_s1_clear;
    logic                        r_s1_use;
    logic                        r_s1_last;
    logic [CIDX_W-1:0]           r_s1_tc;
    logic signed [VALUE_W-1:0]   r_s1_fv;

    // stage 2: products
    logic                        r_s2_valid;
    logic                        r_s2_end;
    logic                        r_s2_clear;
    logic                        r_s2_last;
    logic [CIDX_W-1:0]           r_s2_tc;
    logic signed [PROD_W-1:0]    r_prod [MAX_CLASSES];

    // stage 3: accumulators and end-of-sample snapshot
    logic                        r_s3_valid;
    logic                        r_s3_clear;
    logic [CIDX_W-1:0]           r_s3_tc;
    logic signed [SCORE_W-1:0]   r_acc  [MAX_CLASSES];
    logic signed [SCORE_W-1:0]   r_snap [MAX_CLASSES];
    logic signed [SCORE_W-1:0]   w_sat  [MAX_CLASSES];

    // argmax tree
    logic signed [SCORE_W-1:0]   lf_v  [P];
    logic [CW-1:0]               lf_i  [P];
    logic                        lf_ok [P];
    logic signed [SCORE_W-1:0]   nd_v  [1:2*P-1];
    logic [CW-1:0]               nd_i  [1:2*P-1];
    logic                        nd_ok [1:2*P-1];
    logic [CW-1:0]               w_best;

    logic [1:0]                  w_inflight;
    logic [Q_LEVEL_W:0]          w_credit_used;

    // request decode
    assign w_accept     = push && !full;
    assign w_is_write   = (i_command == CMD_WRITE);
    assign w_is_feature = (i_command == CMD_FEATURE);
    assign w_is_clear   = (i_command == CMD_CLEAR);
    assign w_addr       = AW'(i_feature_index);
    assign w_fidx_ok    = (int'(i_feature_index) < MAX_FEATURES);
    assign w_cidx_ok    = (int'(i_class_index) < MAX_CLASSES);

    // one weight column per class, all read at the feature position
    for (genvar c = 0; c < MAX_CLASSES; c++) begin : g_col
        logic w_we;
        assign w_we = w_accept && w_is_write && w_fidx_ok && w_cidx_ok
                      && (int'(i_class_index) == c);
        lcae_ram #(
            .WIDTH (VALUE_W),
            .DEPTH (MAX_FEATURES)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_we),
            .i_waddr (w_addr),
            .i_wdata (i_weight_value),
            .i_raddr (w_addr),
            .o_rdata (w_rd[c])
        );
    end

    // class count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_classes <= CLASSES_RESET;
        end else if (i_cfg_we) begin
            r_classes <= i_cfg_wdata;
        end
    end

    // stage 1, stage 2 and stage 3 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_end   <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s2_end   <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept && (w_is_feature || w_is_clear);
            r_s1_end   <= w_accept && (w_is_clear || (w_is_feature && i_last_feature));
            r_s2_valid <= r_s1_valid;
            r_s2_end   <= r_s1_end;
            r_s3_valid <= r_s2_end;
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        r_s1_clear <= w_is_clear;
        r_s1_use   <= w_is_feature && w_fidx_ok;
        r_s1_last  <= i_last_feature;
        r_s1_tc    <= i_true_class;
        r_s1_fv    <= i_feature_value;
        r_s2_clear <= r_s1_clear;
        r_s2_last  <= r_s1_last;
        r_s2_tc    <= r_s1_tc;
        r_s3_clear <= r_s2_clear;
        r_s3_tc    <= r_s2_tc;
    end

    // one multiplier per class
    for (genvar c = 0; c < MAX_CLASSES; c++) begin : g_mul
        always_ff @(posedge i_clk) begin
            if (r_s1_use) begin
                r_prod[c] <= r_s1_fv * w_rd[c];
            end else begin
                r_prod[c] <= '0;
            end
        end
    end

    // saturating accumulate, snapshot and restart on the last feature
    for (genvar c = 0; c < MAX_CLASSES; c++) begin : g_acc
        logic signed [SCORE_W:0] w_sum;
        assign w_sum = (SCORE_W+1)'(r_acc[c]) + (SCORE_W+1)'(r_prod[c]);
        always_comb begin
            if (w_sum[SCORE_W] != w_sum[SCORE_W-1]) begin
                w_sat[c] = w_sum[SCORE_W] ? SCORE_MIN : SCORE_MAX;
            end else begin
                w_sat[c] = w_sum[SCORE_W-1:0];
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_acc[c] <= '0;
            end else if (r_s2_valid && !r_s2_clear) begin
                r_acc[c] <= r_s2_last ? '0 : w_sat[c];
            end
        end
        always_ff @(posedge i_clk) begin
            if (r_s2_valid && !r_s2_clear && r_s2_last) begin
                r_snap[c] <= w_sat[c];
            end
        end
    end

    // tree leaves: class 0 always competes, others only while in use
    for (genvar i = 0; i < P; i++) begin : g_leaf
        if (i < MAX_CLASSES) begin : g_real
            assign lf_v[i]  = r_snap[i];
            assign lf_ok[i] = (i == 0) || (i < int'(r_classes));
        end else begin : g_pad
            assign lf_v[i]  = '0;
            assign lf_ok[i] = 1'b0;
        end
        assign lf_i[i] = CW'(i);
    end

    // argmax tree, the right side wins only when strictly greater
    always_comb begin
        for (int k = 0; k < P; k++) begin
            nd_v[P+k]  = lf_v[k];
            nd_i[P+k]  = lf_i[k];
            nd_ok[P+k] = lf_ok[k];
        end
        for (int k = P - 1; k >= 1; k--) begin
            if (nd_ok[2*k+1] && (!nd_ok[2*k] || (nd_v[2*k+1] > nd_v[2*k]))) begin
                nd_v[k]  = nd_v[2*k+1];
                nd_i[k]  = nd_i[2*k+1];
                nd_ok[k] = 1'b1;
            end else begin
                nd_v[k]  = nd_v[2*k];
                nd_i[k]  = nd_i[2*k];
                nd_ok[k] = nd_ok[2*k];
            end
        end
    end

    assign w_best = nd_i[1];

    // verdict into the queue
    assign o_q_push       = r_s3_valid;
    assign o_q_data.clear = r_s3_clear;
    assign o_q_data.pred  = CIDX_W'(w_best);
    assign o_q_data.miss  = (32'(w_best) != 32'(r_s3_tc));

    // queue credit: queued verdicts plus those still in the pipeline
    assign w_inflight    = 2'(r_s1_end) + 2'(r_s2_end) + 2'(r_s3_valid);
    assign w_credit_used = (Q_LEVEL_W+1)'(i_q_level) + (Q_LEVEL_W+1)'(w_inflight);
    assign full          = (w_credit_used >= (Q_LEVEL_W+1)'(Q_DEPTH));

    // the queue can never be promised more than it holds
    a_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_credit_used <= (Q_LEVEL_W+1)'(Q_DEPTH))
        else $error("front: queue credit exceeded");

    // the chosen class is always one in use
    a_best_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3_valid && !r_s3_clear) |-> (w_best == '0 || 32'(w_best) < 32'(r_classes)))
        else $error("front: chosen class not in use");

endmodule

>>> rtl/lcae_queue.sv
// ----------------------------------------------------------------------------
// lcae_queue
// Short verdict queue between the scoring front and the counting back.
// ----------------------------------------------------------------------------
module lcae_queue
    import lcae_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  t_verdict             i_data,
    output logic                 o_valid,
    output t_verdict             o_data,
    input  logic                 i_pop,
    output logic [Q_LEVEL_W-1:0] o_level
);

    t_verdict               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]     r_wp;
    logic [Q_PTR_W-1:0]     r_rp;
    logic [Q_LEVEL_W-1:0]   r_count;
    logic                   w_pop;

    assign w_pop = i_pop && (r_count != '0);

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && w_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rp];
    assign o_level = r_count;

    // a push never lands in a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < Q_LEVEL_W'(Q_DEPTH)))
        else $error("queue: push into full queue");

endmodule

>>> rtl/lcae_back.sv
// ----------------------------------------------------------------------------
// lcae_back
// Applies verdicts to the saturating counters and holds the result register.
// ----------------------------------------------------------------------------
module lcae_back
    import lcae_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  t_verdict            i_q_data,
    output logic                o_q_pop,
    output logic                empty,
    input  logic                pop,
    output logic [CIDX_W-1:0]   o_predicted_class,
    output logic                o_mismatch,
    output logic [COUNT_W-1:0]  o_error_count,
    output logic [COUNT_W-1:0]  o_sample_count
);

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    logic [COUNT_W-1:0] r_err;
    logic [COUNT_W-1:0] r_smp;
    logic [COUNT_W-1:0] n_err;
    logic [COUNT_W-1:0] n_smp;
    logic               r_out_valid;
    logic [CIDX_W-1:0]  r_pred;
    logic               r_miss;
    logic [COUNT_W-1:0] r_err_out;
    logic [COUNT_W-1:0] r_smp_out;
    logic               w_taken;
    logic               w_go;

    // a clear needs no result slot, a sample needs a free one
    assign w_taken = pop && r_out_valid;
    assign w_go    = i_q_valid && (i_q_data.clear || !r_out_valid || w_taken);
    assign o_q_pop = w_go;

    // saturating counter updates
    always_comb begin
        n_err = r_err;
        n_smp = r_smp;
        if (i_q_data.clear) begin
            n_err = '0;
            n_smp = '0;
        end else begin
            if (i_q_data.miss && (r_err != COUNT_MAX)) begin
                n_err = r_err + 1'b1;
            end
            if (r_smp != COUNT_MAX) begin
                n_smp = r_smp + 1'b1;
            end
        end
    end

    // counters and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err       <= '0;
            r_smp       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_go) begin
                r_err <= n_err;
                r_smp <= n_smp;
            end
            if (w_go && !i_q_data.clear) begin
                r_out_valid <= 1'b1;
            end else if (w_taken) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_go && !i_q_data.clear) begin
            r_pred    <= i_q_data.pred;
            r_miss    <= i_q_data.miss;
            r_err_out <= n_err;
            r_smp_out <= n_smp;
        end
    end

    assign empty             = !r_out_valid;
    assign o_predicted_class = r_pred;
    assign o_mismatch        = r_miss;
    assign o_error_count     = r_err_out;
    assign o_sample_count    = r_smp_out;

    // errors only ever count alongside samples
    a_err_le_smp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err <= r_smp)
        else $error("back: error count above sample count");

endmodule

>>> rtl/linear_classifier_argmax_eval.sv
// ----------------------------------------------------------------------------
// linear_classifier_argmax_eval
// Linear classifier scoring with argmax and saturating accuracy counters.
// ----------------------------------------------------------------------------
// Requests enter through push/full: command 0 writes one weight, command 1
// streams one feature of the current sample, command 2 clears both counters,
// command 3 is dropped. A feature request with last_feature set finishes the
// sample and gives one result; nothing else gives a result.
// Results leave through empty/pop: the oldest result sits on the o_ ports
// while empty is low and is taken when pop is high.
// One request is taken every cycle while full is low. An accepted request's
// result passes weight read, multiply, accumulate, argmax into the verdict
// queue, then the counter update into the result register.
// full rises once the eight-entry verdict queue and the three pipeline
// stages hold eight verdicts between them; a stalled receiver therefore
// holds off new requests once nine results wait, one in the result register.
// The class count register is written through i_cfg_we/i_cfg_wdata.
// Reset zeroes the scores and counters and sets the class count to three;
// weights are undefined until written and need no clearing pass.
// ----------------------------------------------------------------------------
module linear_classifier_argmax_eval
    import lcae_pkg::*;
#(
    parameter int MAX_FEATURES = 8,
    parameter int MAX_CLASSES  = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [CMD_W-1:0]          i_command,
    input  logic [FIDX_W-1:0]         i_feature_index,
    input  logic [CIDX_W-1:0]         i_class_index,
    input  logic signed [VALUE_W-1:0] i_weight_value,
    input  logic signed [VALUE_W-1:0] i_feature_value,
    input  logic                      i_last_feature,
    input  logic [CIDX_W-1:0]         i_true_class,
    input  logic                      i_cfg_we,
    input  logic [CFG_W-1:0]          i_cfg_wdata,
    output logic                      empty,
    input  logic                      pop,
    output logic [CIDX_W-1:0]         o_predicted_class,
    output logic                      o_mismatch,
    output logic [COUNT_W-1:0]        o_error_count,
    output logic [COUNT_W-1:0]        o_sample_count
);

    logic                 w_push_q;
    t_verdict             w_push_data;
    logic                 w_q_valid;
    t_verdict             w_q_data;
    logic                 w_q_pop;
    logic [Q_LEVEL_W-1:0] w_q_level;

    // scoring front
    lcae_front #(
        .MAX_FEATURES (MAX_FEATURES),
        .MAX_CLASSES  (MAX_CLASSES)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_command       (i_command),
        .i_feature_index (i_feature_index),
        .i_class_index   (i_class_index),
        .i_weight_value  (i_weight_value),
        .i_feature_value (i_feature_value),
        .i_last_feature  (i_last_feature),
        .i_true_class    (i_true_class),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_q_level       (w_q_level),
        .o_q_push        (w_push_q),
        .o_q_data        (w_push_data)
    );

    // verdict queue
    lcae_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push_q),
        .i_data  (w_push_data),
        .o_valid (w_q_valid),
        .o_data  (w_q_data),
        .i_pop   (w_q_pop),
        .o_level (w_q_level)
    );

    // counting back
    lcae_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (w_q_valid),
        .i_q_data          (w_q_data),
        .o_q_pop           (w_q_pop),
        .empty             (empty),
        .pop               (pop),
        .o_predicted_class (o_predicted_class),
        .o_mismatch        (o_mismatch),
        .o_error_count     (o_error_count),
        .o_sample_count    (o_sample_count)
    );

endmodule
